// ===== design/plas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package plas_pkg;

   localparam int MAX_WIDTH        = 1024;
   localparam int MAX_HEIGHT       = 1024;
   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int COORD_W  = 10;
   localparam int COLOR_W  = 8;
   localparam int TIME_W   = 16;
   localparam int PHASE_W  = 16;
   localparam int ACC_W    = 24;
   localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
   localparam int MAG_W    = 15;
   localparam int SINE_W   = 16;
   localparam int SUM_W    = 18;

   localparam int ISQ_N_W   = 2 * COORD_W + 1 + 8;
   localparam int ISQ_STEPS = (ISQ_N_W + 1) / 2;
   localparam int ISQ_W     = 2 * ISQ_STEPS;
   localparam int RAD_W     = ISQ_STEPS;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [MAG_W-1:0] ONE_Q14 = MAG_W'(16384);

   localparam logic [16:0] KX1  = 17'd80105;
   localparam logic [16:0] KY2  = 17'd106807;
   localparam logic [16:0] KXY3 = 17'd40053;
   localparam logic [16:0] KR4  = 17'd53404;
   localparam logic [13:0] KT1  = 14'd11473;
   localparam logic [13:0] KT2  = 14'd7301;
   localparam logic [13:0] KT3  = 14'd13559;
   localparam logic [13:0] KT4  = 14'd9387;
   localparam logic [PHASE_W-1:0] GREEN_OFS = PHASE_W'(21841);
   localparam logic [PHASE_W-1:0] BLUE_OFS  = PHASE_W'(43693);

   // (2k)(2k+1) for the series terms k = 1..7
   localparam logic [63:0] SERIES_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

   typedef logic [MAG_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } coord_type;

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type       rom;
      logic [63:0]        xa;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         xa   = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (xa * xa) >> 30;
         term = xa;
         sum  = signed'(xa);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / SERIES_DIV[k-1];
            if (k % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rom[i] = MAG_W'((64'(sum) + 64'd32768) >> 16);
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

// ===== design/plas_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface plas_req_if;
   logic                         valid;
   logic                         ready;
   logic [plas_pkg::COORD_W-1:0] pixel_x;
   logic [plas_pkg::COORD_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// ===== design/plas_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface plas_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [plas_pkg::COLOR_W-1:0] red;
   logic [plas_pkg::COLOR_W-1:0] green;
   logic [plas_pkg::COLOR_W-1:0] blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== design/plas_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface plas_csr_if;
   logic                        valid;
   logic                        ready;
   logic [plas_pkg::TIME_W-1:0] frame_time;
   modport source (output valid, output frame_time, input ready);
   modport sink   (input valid, input frame_time, output ready);
endinterface
`default_nettype wire

// ===== design/plas_sine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module plas_sine (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [plas_pkg::PHASE_W-1:0] phase,
   output logic signed [plas_pkg::SINE_W-1:0] sine
);
   localparam plas_pkg::sine_rom_type ROM = plas_pkg::build_sine_rom();
   localparam int PROD_W = 14 + plas_pkg::IDX_W + 1;

   logic [PROD_W-1:0]            prod;
   logic [plas_pkg::IDX_W-1:0]   idx;
   logic [plas_pkg::IDX_W:0]     mirror;
   logic [plas_pkg::IDX_W-1:0]   addr;
   logic                         odd_quad;
   logic [plas_pkg::MAG_W-1:0]   mag_ff;
   logic                         one_ff;
   logic                         neg_ff;
   logic [plas_pkg::MAG_W-1:0]   mag;

   assign prod     = PROD_W'(phase[13:0]) * PROD_W'(plas_pkg::SINE_TABLE_DEPTH);
   assign idx      = plas_pkg::IDX_W'(prod >> 14);
   assign mirror   = (plas_pkg::IDX_W+1)'(plas_pkg::SINE_TABLE_DEPTH) - {1'b0, idx};
   assign odd_quad = phase[14];
   assign addr     = odd_quad ? mirror[plas_pkg::IDX_W-1:0] : idx;

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= ROM[addr];
         one_ff <= odd_quad && (idx == '0);
         neg_ff <= phase[15];
      end
   end

   assign mag  = one_ff ? plas_pkg::ONE_Q14 : mag_ff;
   assign sine = neg_ff ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
endmodule
`default_nettype wire

// ===== design/plas_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module plas_isqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         enable,
   input  wire logic                         in_valid,
   input  wire logic [plas_pkg::ISQ_N_W-1:0] in_n,
   input  wire plas_pkg::coord_type          in_side,
   output logic                              out_valid,
   output logic [plas_pkg::RAD_W-1:0]        out_root,
   output plas_pkg::coord_type               out_side
);
   localparam int S = plas_pkg::ISQ_STEPS;
   localparam int W = plas_pkg::ISQ_W;

   logic [W-1:0]        rem_ff  [S+1];
   logic [W-1:0]        res_ff  [S+1];
   plas_pkg::coord_type side_ff [S+1];
   logic                v_ff    [S+1];

   always_comb begin
      rem_ff[0]  = W'(in_n);
      res_ff[0]  = '0;
      side_ff[0] = in_side;
      v_ff[0]    = in_valid;
   end

   for (genvar k = 0; k < S; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
      logic [W-1:0] trial;
      logic [W-1:0] rem_in;
      logic [W-1:0] res_in;
      always_comb begin
         trial = res_ff[k] + BIT;
         if (rem_ff[k] >= trial) begin
            rem_in = rem_ff[k] - trial;
            res_in = (res_ff[k] >> 1) + BIT;
         end else begin
            rem_in = rem_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (enable) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (enable) begin
            rem_ff[k+1]  <= rem_in;
            res_ff[k+1]  <= res_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[S];
   assign out_root  = res_ff[S][plas_pkg::RAD_W-1:0];
   assign out_side  = side_ff[S];
endmodule
`default_nettype wire

// ===== design/plasma_pixel_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  payload                 transfer
// req_port  in   pixel_x, pixel_y        valid & ready
// rsp_port  out  red, green, blue        valid & ready
// csr_port  in   frame_time              valid & ready (ready always high)
// one pixel per cycle unless the result is stalled
// sine lookups are registered rom reads, seven per pixel
// reset clears the valid bits and frame_time only
// a stalled result freezes the whole pipeline; req_port.ready follows it
module plasma_pixel_generator (
   input wire logic  clock,
   input wire logic  reset,
   plas_req_if.sink  req_port,
   plas_rsp_if.source rsp_port,
   plas_csr_if.sink  csr_port
);
   localparam int CW = plas_pkg::COORD_W;
   localparam int AW = plas_pkg::ACC_W;
   localparam int PW = plas_pkg::PHASE_W;
   localparam int NW = plas_pkg::ISQ_N_W;

   logic                       advance;
   logic [plas_pkg::TIME_W-1:0] time_ff;

   plas_pkg::coord_type s0_ff;
   logic                s0_v_ff;
   plas_pkg::coord_type s0_in;

   logic [plas_pkg::ISQ_N_W-1:0] s1_n_ff;
   plas_pkg::coord_type          s1_ff;
   logic                         s1_v_ff;

   logic                   rt_v;
   logic [plas_pkg::RAD_W-1:0] rt_r;
   plas_pkg::coord_type    rt_side;

   logic [PW-1:0] ph_ff [4];
   logic          ph_v_ff;
   logic [AW-1:0] acc_in [4];

   logic signed [plas_pkg::SINE_W-1:0] wave [4];
   logic                               wv_v_ff;
   logic [PW-1:0]                      vp_ff;
   logic                               vp_v_ff;
   logic signed [plas_pkg::SUM_W-1:0]  v_sum;

   logic signed [plas_pkg::SINE_W-1:0] col [3];
   logic [PW-1:0]                      col_ph [3];
   logic                               cs_v_ff;

   logic [plas_pkg::COLOR_W-1:0] rgb_ff [3];
   logic                         out_v_ff;
   logic [plas_pkg::COLOR_W-1:0] rgb_in [3];

   assign advance        = !out_v_ff || rsp_port.ready;
   assign req_port.ready = advance;
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (csr_port.valid) begin
         time_ff <= csr_port.frame_time;
      end
   end

   always_comb begin
      s0_in.x = (13'(req_port.pixel_x) >= 13'(plas_pkg::MAX_WIDTH))
              ? CW'(plas_pkg::MAX_WIDTH - 1) : req_port.pixel_x;
      s0_in.y = (13'(req_port.pixel_y) >= 13'(plas_pkg::MAX_HEIGHT))
              ? CW'(plas_pkg::MAX_HEIGHT - 1) : req_port.pixel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         ph_v_ff  <= 1'b0;
         wv_v_ff  <= 1'b0;
         vp_v_ff  <= 1'b0;
         cs_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         s0_v_ff  <= req_port.valid;
         s1_v_ff  <= s0_v_ff;
         ph_v_ff  <= rt_v;
         wv_v_ff  <= ph_v_ff;
         vp_v_ff  <= wv_v_ff;
         cs_v_ff  <= vp_v_ff;
         out_v_ff <= cs_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff   <= s0_in;
         s1_ff   <= s0_ff;
         s1_n_ff <= (NW'(s0_ff.x) * NW'(s0_ff.x) + NW'(s0_ff.y) * NW'(s0_ff.y)) << 8;
      end
   end

   plas_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s1_v_ff),
      .in_n      (s1_n_ff),
      .in_side   (s1_ff),
      .out_valid (rt_v),
      .out_root  (rt_r),
      .out_side  (rt_side)
   );

   always_comb begin
      acc_in[0] = AW'(rt_side.x) * AW'(plas_pkg::KX1)
                + AW'(time_ff) * AW'(plas_pkg::KT1);
      acc_in[1] = AW'(rt_side.y) * AW'(plas_pkg::KY2)
                + AW'(time_ff) * AW'(plas_pkg::KT2);
      acc_in[2] = (AW'(rt_side.x) + AW'(rt_side.y)) * AW'(plas_pkg::KXY3)
                + AW'(time_ff) * AW'(plas_pkg::KT3);
      acc_in[3] = AW'((32'(rt_r) * 32'(plas_pkg::KR4)) >> 4)
                - AW'(time_ff) * AW'(plas_pkg::KT4);
   end

   for (genvar w = 0; w < 4; w++) begin : g_wave
      always_ff @(posedge clock) begin
         if (advance) begin
            ph_ff[w] <= acc_in[w][AW-1:8];
         end
      end
      plas_sine u_sine (
         .clock  (clock),
         .enable (advance),
         .phase  (ph_ff[w]),
         .sine   (wave[w])
      );
   end

   assign v_sum = plas_pkg::SUM_W'(wave[0]) + plas_pkg::SUM_W'(wave[1])
                + plas_pkg::SUM_W'(wave[2]) + plas_pkg::SUM_W'(wave[3]);

   always_ff @(posedge clock) begin
      if (advance) begin
         vp_ff <= v_sum[PW:1];
      end
   end

   assign col_ph[0] = vp_ff;
   assign col_ph[1] = vp_ff + plas_pkg::GREEN_OFS;
   assign col_ph[2] = vp_ff + plas_pkg::BLUE_OFS;

   for (genvar c = 0; c < 3; c++) begin : g_color
      logic signed [23:0] num;
      plas_sine u_sine (
         .clock  (clock),
         .enable (advance),
         .phase  (col_ph[c]),
         .sine   (col[c])
      );
      assign num       = 24'sd2097152 + 24'sd127 * 24'(col[c]);
      assign rgb_in[c] = num[21:14];
      always_ff @(posedge clock) begin
         if (advance) begin
            rgb_ff[c] <= rgb_in[c];
         end
      end
   end

   assign rsp_port.valid = out_v_ff;
   assign rsp_port.red   = rgb_ff[0];
   assign rsp_port.green = rgb_ff[1];
   assign rsp_port.blue  = rgb_ff[2];

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.ready) |-> !req_port.ready)
      else $error("input taken while result stalled");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_port.valid)
      else $error("result right after reset");
   a_color_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (rsp_port.red != '0 && rsp_port.green != '0
                          && rsp_port.blue != '0))
      else $error("color channel out of range");
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_port.ready) |=> ($stable(vp_ff) && $stable(cs_v_ff)))
      else $error("pipeline moved during stall");
endmodule
`default_nettype wire
